>>> sv/indexed_list_engine_top_macros.svh
// Assertion macros shared by the list engine RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ILE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("list engine assertion failed");

// The expression must never be true outside reset.
`define ILE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("list engine forbidden condition seen");

`else

`define ILE_ASSERT(lbl, prop)
`define ILE_ASSERT_NEVER(lbl, expr)

`endif

`endif

>>> sv/ile_pkg.sv
package ile_pkg;

  // List size and entry width.
  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  // Fixed field widths of the stream words.
  localparam int CMD_W    = 3;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Internal widths derived from the capacity.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Packed stream word widths, rounded up to whole bytes.
  localparam int IN_BITS    = CMD_W + INDEX_W + VALUE_W;
  localparam int OUT_BITS   = STATUS_W + VALUE_W + COUNT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_REMOVE_AT  = 3'd2,
    CMD_REMOVE_VAL = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Action broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE_AT,
    CELL_REMOVE_VAL
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [POS_W-1:0]      index;
    logic [POS_W-1:0]      count;
    logic [WORD_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

>>> sv/ile_cell.sv
module ile_cell (
  input  logic                          clk_i,
  input  logic [ile_pkg::POS_W-1:0]     pos_i,
  input  ile_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ile_pkg::WORD_WIDTH-1:0] left_word_i,
  input  logic [ile_pkg::WORD_WIDTH-1:0] right_word_i,
  input  logic                          found_i,
  output logic                          found_o,
  output logic [ile_pkg::WORD_WIDTH-1:0] word_o,
  output logic [ile_pkg::WORD_WIDTH-1:0] rd_word_o
);

  logic [ile_pkg::WORD_WIDTH-1:0] word_q;
  logic [ile_pkg::WORD_WIDTH-1:0] word_d;
  logic                           held;
  logic                           match;

  // Match only counts for positions that hold an entry; the found flag
  // ripples right so every cell at or after the first match sees it.
  assign held    = (pos_i < ctrl_i.count);
  assign match   = held && (word_q == ctrl_i.value);
  assign found_o = found_i | match;

  assign word_o    = word_q;
  assign rd_word_o = (pos_i == ctrl_i.index) ? word_q : '0;

  // Select this cell's next word from the value or a neighbor.
  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.op)
      ile_pkg::CELL_HOLD: begin
        word_d = word_q;
      end
      ile_pkg::CELL_APPEND: begin
        if (pos_i == ctrl_i.count) word_d = ctrl_i.value;
      end
      ile_pkg::CELL_INSERT: begin
        if (pos_i == ctrl_i.index) begin
          word_d = ctrl_i.value;
        end else if (pos_i > ctrl_i.index) begin
          word_d = left_word_i;
        end
      end
      ile_pkg::CELL_REMOVE_AT: begin
        if (pos_i >= ctrl_i.index) word_d = right_word_i;
      end
      ile_pkg::CELL_REMOVE_VAL: begin
        if (found_o) word_d = right_word_i;
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  // Entry storage; contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

>>> sv/indexed_list_engine_top.sv
// Ordered list of words held in a row of entry cells.
// Slave stream: one word per command, tdata = {value, index, cmd} from bit 0:
// cmd (3 bits), index (5 bits), value (32 bits).
// Master stream: one word per command, tdata from bit 0: status (2 bits),
// read_word (32 bits), entry_count (5 bits).
// Commands are append, insert at index, remove at index, remove first equal
// value, read at index and clear. Status reports ok, bad index, full or not
// found; read_word is zero unless a read succeeds.
// The result word is registered and valid in the cycle after the command
// is accepted. Throughput, set by the cell row, is one command per cycle
// while results are taken; all cells shift, compare and load in the same cycle.
// A ripple of found flags through the cells picks the first match.
// Reset empties the list and drops the output valid; it takes no clearing pass.
// When the receiver stalls, the result is held and s_axis_tready drops
// until that result is taken, so no command is lost or reordered.
`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: cmd[2:0], index[7:3], value[39:8].
  input  logic [ile_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: status[1:0], read_word[33:2], entry_count[38:34].
  output logic [ile_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int CAP     = ile_pkg::CAPACITY;
  localparam int WW      = ile_pkg::WORD_WIDTH;
  localparam int CW      = ile_pkg::COUNT_W;
  localparam int CNT_LSB = ile_pkg::STATUS_W + ile_pkg::VALUE_W;

  logic                            accept;
  ile_pkg::cmd_e                   cmd;
  logic [ile_pkg::INDEX_W-1:0]     index;
  logic [ile_pkg::VALUE_W-1:0]     value;
  logic [ile_pkg::POS_W-1:0]       idx_ext;
  logic [ile_pkg::POS_W-1:0]       cnt_ext;
  logic                            full;

  logic [ile_pkg::CNT_W-1:0]       count_q, count_d;
  logic                            out_valid_q;
  logic [ile_pkg::OUT_DATA_W-1:0]  out_data_q, out_data_d;

  ile_pkg::cell_ctrl_t             ctrl;
  ile_pkg::cell_op_e               op;
  ile_pkg::status_e                status;
  logic [ile_pkg::VALUE_W-1:0]     rd_word;
  logic [WW-1:0]                   rd_any;

  logic [WW-1:0]                   words   [CAP];
  logic [WW-1:0]                   rd_words[CAP];
  logic [CAP:0]                    found;

  // Handshake and field unpacking.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = ile_pkg::cmd_e'(s_axis_tdata[ile_pkg::CMD_W-1:0]);
  assign index         = s_axis_tdata[ile_pkg::CMD_W +: ile_pkg::INDEX_W];
  assign value = s_axis_tdata[ile_pkg::CMD_W + ile_pkg::INDEX_W +: ile_pkg::VALUE_W];

  assign idx_ext = ile_pkg::POS_W'(index);
  assign cnt_ext = ile_pkg::POS_W'(count_q);
  assign full    = (count_q == ile_pkg::CNT_W'(CAP));

  // Broadcast to the cells; they act only on an accepted command.
  assign ctrl.op    = accept ? op : ile_pkg::CELL_HOLD;
  assign ctrl.index = idx_ext;
  assign ctrl.count = cnt_ext;
  assign ctrl.value = value[WW-1:0];

  // Row of entry cells.
  assign found[0] = 1'b0;
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [WW-1:0] left_w;
    logic [WW-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[g+1];
    end
    ile_cell u_cell (
      .clk_i        (clk_i),
      .pos_i        (ile_pkg::POS_W'(g)),
      .ctrl_i       (ctrl),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .found_i      (found[g]),
      .found_o      (found[g+1]),
      .word_o       (words[g]),
      .rd_word_o    (rd_words[g])
    );
  end

  // Only the addressed cell drives a nonzero read word.
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAP; k++) begin
      rd_any = rd_any | rd_words[k];
    end
  end

  // Command decode, status and new count.
  always_comb begin
    op      = ile_pkg::CELL_HOLD;
    status  = ile_pkg::ST_OK;
    rd_word = '0;
    count_d = count_q;
    unique case (cmd)
      ile_pkg::CMD_APPEND: begin
        if (full) begin
          status = ile_pkg::ST_FULL;
        end else begin
          op      = ile_pkg::CELL_APPEND;
          count_d = count_q + 1'b1;
        end
      end
      ile_pkg::CMD_INSERT: begin
        if (idx_ext > cnt_ext) begin
          status = ile_pkg::ST_BAD_INDEX;
        end else if (full) begin
          status = ile_pkg::ST_FULL;
        end else begin
          op      = ile_pkg::CELL_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      ile_pkg::CMD_REMOVE_AT: begin
        if (idx_ext >= cnt_ext) begin
          status = ile_pkg::ST_BAD_INDEX;
        end else begin
          op      = ile_pkg::CELL_REMOVE_AT;
          count_d = count_q - 1'b1;
        end
      end
      ile_pkg::CMD_REMOVE_VAL: begin
        if (!found[CAP]) begin
          status = ile_pkg::ST_NOT_FOUND;
        end else begin
          op      = ile_pkg::CELL_REMOVE_VAL;
          count_d = count_q - 1'b1;
        end
      end
      ile_pkg::CMD_READ: begin
        if (idx_ext >= cnt_ext) begin
          status = ile_pkg::ST_BAD_INDEX;
        end else begin
          rd_word = ile_pkg::VALUE_W'(rd_any);
        end
      end
      ile_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status = ile_pkg::ST_OK;
      end
    endcase
  end

  // Result word packing.
  assign out_data_d = ile_pkg::OUT_DATA_W'({CW'(count_d), rd_word, status});

  // Count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The held count never passes the capacity.
  `ILE_ASSERT(a_count_range, count_q <= ile_pkg::CNT_W'(CAP))
  // Every accepted command shows a result in the next cycle.
  `ILE_ASSERT(a_result_follows, accept |=> m_axis_tvalid)
  // The reported count tracks the stored count.
  `ILE_ASSERT(a_count_echo, m_axis_tvalid |-> (m_axis_tdata[CNT_LSB +: CW] == CW'(count_q)))
  // A found value implies the list was not empty.
  `ILE_ASSERT_NEVER(a_found_empty, found[CAP] && (count_q == '0))

endmodule

>>> test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  // Command codes that the block does not use; it must answer them with ok.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // One result word, split into its fields.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_word;
    logic [COUNT_W-1:0]  entry_count;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the list, kept in step with accepted commands.
  logic [WORD_WIDTH-1:0] list_words [CAPACITY];
  int                    list_len = 0;

  list_result_t pending_results [$];
  int           n_errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  indexed_list_engine_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Apply one command to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0]   c,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input logic [VALUE_W-1:0] v);
    list_result_t r;
    int           drop_pos;
    r.status = ST_OK;
    r.read_word = '0;
    drop_pos = -1;
    case (c)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = v;
          list_len++;
        end
      end
      CMD_INSERT: begin
        // The index check takes precedence over the full check.
        if (idx > list_len) begin
          r.status = ST_BAD_INDEX;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int j = list_len; j > idx; j--) list_words[j] = list_words[j-1];
          list_words[idx] = v;
          list_len++;
        end
      end
      CMD_REMOVE_AT: begin
        if (idx >= list_len) r.status = ST_BAD_INDEX;
        else drop_pos = idx;
      end
      CMD_REMOVE_VAL: begin
        for (int j = 0; j < list_len; j++) begin
          if (drop_pos < 0 && list_words[j] == v) drop_pos = j;
        end
        if (drop_pos < 0) r.status = ST_NOT_FOUND;
      end
      CMD_READ: begin
        if (idx >= list_len) r.status = ST_BAD_INDEX;
        else r.read_word = list_words[idx];
      end
      CMD_CLEAR: begin
        list_len = 0;
      end
      default: ;
    endcase
    // Close the gap left by a removal.
    if (drop_pos >= 0) begin
      for (int j = drop_pos; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
      list_len--;
    end
    r.entry_count = COUNT_W'(list_len);
    return r;
  endfunction

  // Offer one command word, with random gaps before it, and log its result.
  task automatic send_command(input logic [CMD_W-1:0]   c,
                              input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] v);
    logic [IN_DATA_W-1:0] word_bits;
    word_bits = (IN_DATA_W'(v) << (CMD_W + INDEX_W)) | (IN_DATA_W'(idx) << CMD_W)
                | IN_DATA_W'(c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word_bits;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_list_command(c, idx, v));
  endtask

  // Hold off the sender until every result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Commands on an empty list: nothing to read, remove or find.
  task automatic test_empty_list();
    send_command(CMD_READ, 5'd0, 32'h0);
    send_command(CMD_REMOVE_AT, 5'd0, 32'hFFFF_FFFF);
    send_command(CMD_REMOVE_VAL, 5'd0, 32'h0);
  endtask

  // Fill the list to capacity, with a duplicated value and the all-ones word.
  task automatic test_fill_to_capacity();
    send_command(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
    for (int i = 1; i < CAPACITY; i++) begin
      send_command(CMD_APPEND, 5'h1F, (i % 5 == 2) ? 32'h0000_0005 : 32'(i * 32'h1111_0001));
    end
    send_command(CMD_APPEND, 5'd0, 32'h0);
  endtask

  // A full list refuses growth; a bad insert index is reported before full.
  task automatic test_full_list();
    send_command(CMD_APPEND, 5'd0, 32'h1234_5678);
    send_command(CMD_INSERT, 5'd16, 32'hA5A5_A5A5);
    send_command(CMD_INSERT, 5'd17, 32'h5A5A_5A5A);
    send_command(CMD_READ, 5'd15, 32'h0);
    send_command(CMD_READ, 5'h1F, 32'h0);
  endtask

  // Removal of the first match, a spare command code and clear.
  task automatic test_search_and_clear();
    send_command(CMD_REMOVE_VAL, 5'd0, 32'h0000_0005);
    send_command(CMD_READ, 5'd2, 32'h0);
    send_command(CMD_SPARE_B, 5'h1F, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR, 5'd9, 32'h0);
    send_command(CMD_READ, 5'd0, 32'h0);
  endtask

  // Random commands, mostly with indexes and values that hit the list.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    logic [CMD_W-1:0]   c;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] v;
    int                 pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 25) c = CMD_APPEND;
      else if (pick < 45) c = CMD_INSERT;
      else if (pick < 60) c = CMD_REMOVE_AT;
      else if (pick < 75) c = CMD_REMOVE_VAL;
      else if (pick < 94) c = CMD_READ;
      else if (pick < 97) c = CMD_CLEAR;
      else c = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;

      if ($urandom_range(9) < 8) idx = INDEX_W'($urandom_range(list_len));
      else idx = INDEX_W'($urandom_range(31));

      // Small values make duplicates; searches usually target a held word.
      if (c == CMD_REMOVE_VAL && list_len > 0 && $urandom_range(9) < 7)
        v = list_words[$urandom_range(list_len - 1)];
      else if ($urandom_range(1))
        v = VALUE_W'($urandom_range(3));
      else
        v = $urandom;

      send_command(c, idx, v);
    end
    wait_for_results();
  endtask

  // Receiver side: random stalls at the current rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command pending: %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[STATUS_W-1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 m_axis_tdata[STATUS_W-1:0]);
          n_errors++;
        end
        if (m_axis_tdata[STATUS_W +: VALUE_W] !== want.read_word) begin
          $error("read_word: expected %h, got %h", want.read_word,
                 m_axis_tdata[STATUS_W +: VALUE_W]);
          n_errors++;
        end
        if (m_axis_tdata[STATUS_W + VALUE_W +: COUNT_W] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_axis_tdata[STATUS_W + VALUE_W +: COUNT_W]);
          n_errors++;
        end
      end
    end
  end

  // Directed cases, then random phases with different idle and stall patterns.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_fill_to_capacity();
    test_full_list();
    test_search_and_clear();
    wait_for_results();
    test_random_traffic(500, 0, 0);
    test_random_traffic(500, 74, 0);
    test_random_traffic(500, 0, 74);
    test_random_traffic(500, 21, 21);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
